/* rtl/bru_pkg.sv */
// Shared types and constants of the BMP row pixel unpacker.
// Used by every module of the block but bru_ram, and by the channel interface users.
package bru_pkg;

  localparam int unsigned MAX_WIDTH  = 8192;
  localparam int unsigned WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROWB_W     = $clog2(4 * MAX_WIDTH + 4);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd1;

  localparam logic FUNC_PIXEL   = 1'b0;
  localparam logic FUNC_PALETTE = 1'b1;

  typedef enum logic [2:0] {
    FMT_1BPP   = 3'd0,
    FMT_4BPP   = 3'd1,
    FMT_8BPP   = 3'd2,
    FMT_RGB555 = 3'd3,
    FMT_RGB565 = 3'd4,
    FMT_BGR24  = 3'd5,
    FMT_BGRA32 = 3'd6,
    FMT_ABGR32 = 3'd7
  } fmt_e;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] pal_index;
    logic [7:0] pal_blue;
    logic [7:0] pal_green;
    logic [7:0] pal_red;
    logic [7:0] pal_reserved;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       row_end;
    logic       last;
    logic       alpha_seen;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  // Decoded configuration handed from the register block to the sequencer
  typedef struct packed {
    fmt_e              fmt;
    logic [WID_W-1:0]  width;
    logic [ROWB_W-1:0] rd;
    logic [ROWB_W-1:0] pad;
    logic              clear;
  } cfg_t;

  // One pixel on its way to the palette read and output stages
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       use_pal;
    logic       pal_zero;
    logic       row_end;
    logic       last;
    logic       alpha_seen;
  } pix_desc_t;

endpackage

/* rtl/bru_chan_if.sv */
// Valid/ready channel carrying one payload struct per beat.
// Payload types come from bru_pkg.
interface bru_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bmp_row_pixel_unpacker.sv */
// BMP row pixel unpacker: raw row bytes in, 8-bit BGRA pixels out.
// Depends on bru_pkg, bru_chan_if, bru_cfg, bru_seq, bru_ram, bru_out.
//
// Channels: in_if takes one beat per row byte (func = pixel) or palette
// entry (func = palette); out_if gives one beat per decoded pixel, with
// row_end on the last pixel of a row and last on the final pixel of a byte.
// cfg_if writes pixel_format (index 0) or row_width (index 1); it is always
// ready, and a write restarts row position and alpha tracking.
// Flow: a taken byte is held in the input register; its pixels then pass
// the palette stage and the output register, one pixel per cycle (set by
// the single palette read port) while the palette stage can take it. A
// byte yields up to two pixels for 4 bpp, up to eight for 1 bpp and at most
// one for 8 bpp and wider formats; pad bytes and palette writes yield none.
// Reset: format 24-bit BGR, width 1, row position and alpha cleared; the
// palette is not cleared and must be written before it is used.
// Stall: a held output keeps its beat; the palette stage and the input
// register still fill behind it, and in_if.ready drops once they are full.
module bmp_row_pixel_unpacker #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bru_chan_if.sink   cfg_if,
  bru_chan_if.sink   in_if,
  bru_chan_if.source out_if
);
  import bru_pkg::*;

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  cfg_t        cfg;
  logic        p_ready;
  logic        pix_valid;
  pix_desc_t   pix;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  bru_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  bru_seq #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_i       (cfg),
    .p_ready_i   (p_ready),
    .pix_valid_o (pix_valid),
    .pix_o       (pix),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  bru_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bru_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .ram_rdata_i (ram_rdata),
    .p_ready_o   (p_ready),
    .out_if      (out_if)
  );

endmodule

/* rtl/bru_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bru_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bru_cfg.sv */
// Configuration registers: pixel format and row width, plus derived row
// byte counts. Depends on bru_pkg and bru_chan_if.
module bru_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  bru_chan_if.sink      cfg_if,
  output bru_pkg::cfg_t cfg_o
);
  import bru_pkg::*;

  fmt_e              fmt_q, fmt_d;
  logic [WID_W-1:0]  width_q, width_d;
  logic [ROWB_W-1:0] rd_q, rd_d;
  logic [ROWB_W-1:0] pad_q, pad_d;
  logic [ROWB_W-1:0] w_ext;
  logic [13:0]       raw;
  logic              clear;

  assign cfg_if.ready = 1'b1;
  assign raw          = cfg_if.data.value[13:0];

  always_comb begin
    fmt_d   = fmt_q;
    width_d = width_q;
    clear   = 1'b0;
    if (cfg_if.valid) begin
      case (cfg_if.data.index)
        REG_PIXEL_FORMAT: begin
          fmt_d = fmt_e'(cfg_if.data.value[2:0]);
          clear = 1'b1;
        end
        REG_ROW_WIDTH: begin
          if (raw == 14'd0) begin
            width_d = WID_W'(1);
          end else if (32'(raw) > MAX_WIDTH) begin
            width_d = WID_W'(MAX_WIDTH);
          end else begin
            width_d = WID_W'(raw);
          end
          clear = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // data bytes per row, then padded to a 4-byte multiple
  always_comb begin
    w_ext = ROWB_W'(width_d);
    case (fmt_d)
      FMT_1BPP:   rd_d = (w_ext + ROWB_W'(7)) >> 3;
      FMT_4BPP:   rd_d = (w_ext + ROWB_W'(1)) >> 1;
      FMT_8BPP:   rd_d = w_ext;
      FMT_RGB555,
      FMT_RGB565: rd_d = w_ext << 1;
      FMT_BGR24:  rd_d = w_ext + (w_ext << 1);
      default:    rd_d = w_ext << 2;
    endcase
    pad_d = (rd_d + ROWB_W'(3)) & ~ROWB_W'(3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_BGR24;
      width_q <= WID_W'(1);
      rd_q    <= ROWB_W'(3);
      pad_q   <= ROWB_W'(4);
    end else begin
      fmt_q   <= fmt_d;
      width_q <= width_d;
      rd_q    <= rd_d;
      pad_q   <= pad_d;
    end
  end

  assign cfg_o.fmt   = fmt_q;
  assign cfg_o.width = width_q;
  assign cfg_o.rd    = rd_q;
  assign cfg_o.pad   = pad_q;
  assign cfg_o.clear = clear;

endmodule

/* rtl/bru_seq.sv */
// Input register and pixel sequencer: row position, partial pixel and
// alpha tracking, palette writes and reads. Depends on bru_pkg, bru_chan_if.
module bru_seq #(
  parameter int unsigned PALETTE_DEPTH = 256,
  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bru_chan_if.sink           in_if,
  input  bru_pkg::cfg_t      cfg_i,
  input  logic               p_ready_i,
  output logic               pix_valid_o,
  output bru_pkg::pix_desc_t pix_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [31:0]        ram_wdata_o,
  output logic               ram_re_o,
  output logic [AW-1:0]      ram_raddr_o
);
  import bru_pkg::*;

  localparam int unsigned CMP_W = WID_W + 1;

  logic              s_valid_q, s_valid_d;
  in_item_t          s_item_q;
  logic [2:0]        k_q, k_d;
  logic [ROWB_W-1:0] bir_q, bir_d, bir_n;
  logic [COL_W-1:0]  col_q, col_d;
  logic [2:0][7:0]   part_q, part_d;
  logic [1:0]        pcnt_q, pcnt_d;
  logic              fa_known_q, fa_known_d;
  logic              fa_full_q, fa_full_d;
  logic              aflag_q, aflag_d;

  logic [7:0]  v, idx, b, g, r, a;
  logic [15:0] d16;
  logic        pal_wr, active, col_end, emit, sub_done, use_pal, is32;
  logic        full_n, flag_n, step, finish, issue, accept;

  assign in_if.ready = !s_valid_q || finish;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    v        = s_item_q.data_byte;
    d16      = {v, part_q[0]};
    pal_wr   = s_item_q.func == FUNC_PALETTE;
    active   = !pal_wr && (bir_q < cfg_i.rd);
    col_end  = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(cfg_i.width);
    idx      = v;
    emit     = 1'b0;
    sub_done = 1'b1;
    use_pal  = 1'b0;
    b        = part_q[0];
    g        = part_q[1];
    r        = v;
    a        = 8'hff;
    case (cfg_i.fmt)
      FMT_1BPP: begin
        use_pal  = 1'b1;
        emit     = active;
        idx      = {7'd0, v[3'd7 - k_q]};
        sub_done = !active || col_end || (k_q == 3'd7);
      end
      FMT_4BPP: begin
        use_pal  = 1'b1;
        emit     = active;
        idx      = k_q[0] ? {4'd0, v[3:0]} : {4'd0, v[7:4]};
        sub_done = !active || col_end || k_q[0];
      end
      FMT_8BPP: begin
        use_pal = 1'b1;
        emit    = active;
      end
      FMT_RGB555: begin
        emit = active && (pcnt_q != 2'd0);
        b    = {d16[4:0], d16[4:2]};
        g    = {d16[9:5], d16[9:7]};
        r    = {d16[14:10], d16[14:12]};
      end
      FMT_RGB565: begin
        emit = active && (pcnt_q != 2'd0);
        b    = {d16[4:0], d16[4:2]};
        g    = {d16[10:5], d16[10:9]};
        r    = {d16[15:11], d16[15:13]};
      end
      FMT_BGR24: begin
        emit = active && (pcnt_q == 2'd2);
      end
      FMT_BGRA32: begin
        emit = active && (pcnt_q == 2'd3);
        r    = part_q[2];
        a    = v;
      end
      FMT_ABGR32: begin
        emit = active && (pcnt_q == 2'd3);
        a    = part_q[0];
        b    = part_q[1];
        g    = part_q[2];
      end
      default: ;
    endcase

    is32   = (cfg_i.fmt == FMT_BGRA32) || (cfg_i.fmt == FMT_ABGR32);
    // the first 32-bit pixel decides which alpha counts as opaque
    full_n = fa_known_q ? fa_full_q : (a != 8'h00);
    flag_n = aflag_q || (a != (full_n ? 8'hff : 8'h00));

    step   = s_valid_q && (!emit || p_ready_i);
    finish = step && sub_done;
    issue  = s_valid_q && emit && p_ready_i;
  end

  always_comb begin
    s_valid_d  = s_valid_q;
    k_d        = k_q;
    bir_d      = bir_q;
    bir_n      = bir_q + ROWB_W'(1);
    col_d      = col_q;
    part_d     = part_q;
    pcnt_d     = pcnt_q;
    fa_known_d = fa_known_q;
    fa_full_d  = fa_full_q;
    aflag_d    = aflag_q;

    if (finish) begin
      s_valid_d = 1'b0;
    end
    if (accept) begin
      s_valid_d = 1'b1;
    end
    if (step) begin
      k_d = sub_done ? 3'd0 : k_q + 3'd1;
    end
    if (issue) begin
      col_d = col_end ? '0 : col_q + COL_W'(1);
      if (is32) begin
        fa_known_d = 1'b1;
        fa_full_d  = full_n;
        aflag_d    = flag_n;
      end
    end
    if (finish && !pal_wr) begin
      if (active && !use_pal) begin
        if (emit) begin
          part_d = '0;
          pcnt_d = 2'd0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (pcnt_q == 2'(i)) begin
              part_d[i] = v;
            end
          end
          pcnt_d = pcnt_q + 2'd1;
        end
      end
      // end of padded row: start the next one clean
      if (bir_n >= cfg_i.pad) begin
        bir_d  = '0;
        col_d  = '0;
        part_d = '0;
        pcnt_d = 2'd0;
      end else begin
        bir_d = bir_n;
      end
    end
    if (cfg_i.clear) begin
      bir_d      = '0;
      col_d      = '0;
      part_d     = '0;
      pcnt_d     = 2'd0;
      fa_known_d = 1'b0;
      fa_full_d  = 1'b0;
      aflag_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q  <= 1'b0;
      k_q        <= 3'd0;
      bir_q      <= '0;
      col_q      <= '0;
      part_q     <= '0;
      pcnt_q     <= 2'd0;
      fa_known_q <= 1'b0;
      fa_full_q  <= 1'b0;
      aflag_q    <= 1'b0;
    end else begin
      s_valid_q  <= s_valid_d;
      k_q        <= k_d;
      bir_q      <= bir_d;
      col_q      <= col_d;
      part_q     <= part_d;
      pcnt_q     <= pcnt_d;
      fa_known_q <= fa_known_d;
      fa_full_q  <= fa_full_d;
      aflag_q    <= aflag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_item_q <= in_if.data;
    end
  end

  assign ram_we_o    = s_valid_q && pal_wr && (32'(s_item_q.pal_index) < PALETTE_DEPTH);
  assign ram_waddr_o = AW'(s_item_q.pal_index);
  assign ram_wdata_o = {s_item_q.pal_reserved, s_item_q.pal_red,
                        s_item_q.pal_green, s_item_q.pal_blue};
  assign ram_re_o    = issue && use_pal;
  assign ram_raddr_o = AW'(idx);

  assign pix_valid_o      = issue;
  assign pix_o.blue       = b;
  assign pix_o.green      = g;
  assign pix_o.red        = r;
  assign pix_o.alpha      = a;
  assign pix_o.use_pal    = use_pal;
  assign pix_o.pal_zero   = 32'(idx) >= PALETTE_DEPTH;
  assign pix_o.row_end    = col_end;
  assign pix_o.last       = sub_done;
  assign pix_o.alpha_seen = is32 ? flag_n : aflag_q;

endmodule

/* rtl/bru_out.sv */
// Palette read stage and output register; picks palette or direct color.
// Depends on bru_pkg and bru_chan_if.
module bru_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pix_valid_i,
  input  bru_pkg::pix_desc_t pix_i,
  input  logic [31:0]        ram_rdata_i,
  output logic               p_ready_o,
  bru_chan_if.source         out_if
);
  import bru_pkg::*;

  logic      p_valid_q, p_valid_d;
  pix_desc_t p_q;
  logic      o_valid_q, o_valid_d;
  pix_out_t  o_q, o_d;
  logic      o_free, p_move;

  assign o_free    = !o_valid_q || out_if.ready;
  assign p_ready_o = !p_valid_q || o_free;
  assign p_move    = p_valid_q && o_free;

  always_comb begin
    o_d.row_end    = p_q.row_end;
    o_d.last       = p_q.last;
    o_d.alpha_seen = p_q.alpha_seen;
    if (!p_q.use_pal) begin
      o_d.blue  = p_q.blue;
      o_d.green = p_q.green;
      o_d.red   = p_q.red;
      o_d.alpha = p_q.alpha;
    end else if (p_q.pal_zero) begin
      o_d.blue  = 8'h00;
      o_d.green = 8'h00;
      o_d.red   = 8'h00;
      o_d.alpha = 8'h00;
    end else begin
      o_d.blue  = ram_rdata_i[7:0];
      o_d.green = ram_rdata_i[15:8];
      o_d.red   = ram_rdata_i[23:16];
      o_d.alpha = ram_rdata_i[31:24];
    end

    p_valid_d = p_valid_q;
    if (p_move) begin
      p_valid_d = 1'b0;
    end
    if (pix_valid_i) begin
      p_valid_d = 1'b1;
    end

    o_valid_d = o_valid_q;
    if (out_if.ready) begin
      o_valid_d = 1'b0;
    end
    if (p_move) begin
      o_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_valid_i) begin
      p_q <= pix_i;
    end
    if (p_move) begin
      o_q <= o_d;
    end
  end

  assign out_if.valid = o_valid_q;
  assign out_if.data  = o_q;

endmodule
